// ===== sv/dpst_pkg.sv =====
// Package for the dirty page set table.
// Holds field widths, request kind codes and the controller/datapath link types.
// No dependencies.
package dpst_pkg;

	localparam int KIND_W  = 2;
	localparam int FIELD_W = 52;
	localparam int STAMP_W = 64;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== sv/dpst_ctrl.sv =====
// Controller of the dirty page set table: sequences load, table scan and final result.
// Depends on dpst_pkg.
module dpst_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dpst_pkg::KIND_W-1:0] kind,
	input  dpst_pkg::ctrl_sts_t        sts,
	output dpst_pkg::ctrl_cmd_t        cmd
);
	import dpst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.finish = (state_q == ST_FINISH) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && kind != KIND_UNUSED) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/dpst_datapath.sv =====
// Datapath of the dirty page set table: entry memory, scan pipeline and result register.
// Depends on dpst_pkg; driven by dpst_ctrl.
module dpst_datapath #(
	parameter int CAPACITY  = 64,
	parameter int PAGE_BITS = 52
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpst_pkg::ctrl_cmd_t          cmd,
	output dpst_pkg::ctrl_sts_t          sts,
	input  logic [dpst_pkg::KIND_W-1:0]  kind,
	input  logic [dpst_pkg::FIELD_W-1:0] page_in,
	input  logic [dpst_pkg::STAMP_W-1:0] stamp_in,
	input  logic [dpst_pkg::FIELD_W-1:0] range_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         status,
	output logic                         found,
	output logic [dpst_pkg::FIELD_W-1:0] page_out,
	output logic [dpst_pkg::STAMP_W-1:0] stamp_out,
	output logic                         last
);
	import dpst_pkg::*;

	localparam int PW = (PAGE_BITS < FIELD_W) ? PAGE_BITS : FIELD_W;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [PW-1:0]      page_mem [CAPACITY];
	logic [STAMP_W-1:0] stamp_mem [CAPACITY];

	logic [KIND_W-1:0]  kind_q;
	logic [PW-1:0]      page_q;
	logic [PW-1:0]      end_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_idx_q;
	logic               vld_s1;
	logic [PW-1:0]      page_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic               hit_q;
	logic [STAMP_W-1:0] hit_stamp_q;
	logic               pend_vld_q;
	logic [PW-1:0]      pend_page_q;
	logic [STAMP_W-1:0] pend_stamp_q;
	logic               out_vld_q;
	logic               out_status_q;
	logic               out_found_q;
	logic [PW-1:0]      out_page_q;
	logic [STAMP_W-1:0] out_stamp_q;
	logic               out_last_q;

	logic               out_free;
	logic               adv;
	logic               more;
	logic               rd_en;
	logic               take;
	logic               is_range;
	logic               eq_s1;
	logic               in_range_s1;
	logic               push_mid;
	logic               full;
	logic               wr_en;
	logic               fin_status;
	logic               fin_found;
	logic [PW-1:0]      fin_page;
	logic [STAMP_W-1:0] fin_stamp;

	assign out_free    = !out_vld_q || out_ready;
	assign adv         = cmd.scan && out_free;
	assign more        = rd_idx_q < count_q;
	assign rd_en       = adv && more;
	assign take        = adv && vld_s1;
	assign is_range    = (kind_q == KIND_RANGE);
	assign eq_s1       = (page_s1 == page_q);
	assign in_range_s1 = (page_s1 >= page_q) && (page_s1 <= end_q);
	assign push_mid    = take && is_range && in_range_s1 && pend_vld_q;
	assign full        = (count_q >= CW'(CAPACITY));
	assign wr_en       = cmd.finish && (kind_q == KIND_INSERT) && !hit_q && !full;

	assign sts.scan_done = !more && !vld_s1;
	assign sts.out_free  = out_free;

	always_comb begin
		fin_status = 1'b0;
		fin_found  = 1'b0;
		fin_page   = '0;
		fin_stamp  = '0;
		unique case (kind_q)
			KIND_INSERT: begin
				fin_status = !hit_q && full;
			end
			KIND_LOOKUP: begin
				fin_found = hit_q;
				fin_page  = page_q;
				fin_stamp = hit_q ? hit_stamp_q : '0;
			end
			KIND_RANGE: begin
				fin_found = pend_vld_q;
				fin_page  = pend_vld_q ? pend_page_q : '0;
				fin_stamp = pend_vld_q ? pend_stamp_q : '0;
			end
			default: begin
				fin_status = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem[count_q[AW-1:0]]  <= page_q;
			stamp_mem[count_q[AW-1:0]] <= stamp_q;
		end
		if (rd_en) begin
			page_s1  <= page_mem[rd_idx_q[AW-1:0]];
			stamp_s1 <= stamp_mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q   <= '0;
				vld_s1     <= 1'b0;
				hit_q      <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (adv) begin
					vld_s1 <= rd_en;
				end
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (take && !is_range && eq_s1) begin
					hit_q <= 1'b1;
				end
				if (take && is_range && in_range_s1) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (push_mid || cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			page_q  <= page_in[PW-1:0];
			end_q   <= range_end[PW-1:0];
			stamp_q <= stamp_in;
		end
		if (take && !is_range && eq_s1) begin
			hit_stamp_q <= stamp_s1;
		end
		if (take && is_range && in_range_s1) begin
			pend_page_q  <= page_s1;
			pend_stamp_q <= stamp_s1;
		end
		if (push_mid) begin
			out_status_q <= 1'b0;
			out_found_q  <= 1'b1;
			out_page_q   <= pend_page_q;
			out_stamp_q  <= pend_stamp_q;
			out_last_q   <= 1'b0;
		end else if (cmd.finish) begin
			out_status_q <= fin_status;
			out_found_q  <= fin_found;
			out_page_q   <= fin_page;
			out_stamp_q  <= fin_stamp;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid = out_vld_q;
	assign status    = out_status_q;
	assign found     = out_found_q;
	assign page_out  = FIELD_W'(out_page_q);
	assign stamp_out = out_stamp_q;
	assign last      = out_last_q;

endmodule

// ===== sv/dirty_page_set_table.sv =====
// Top level of the dirty page set table: a deduplicating table of page numbers
// with timestamps. Every request (insert, lookup or range query) reads the
// stored entries one per cycle from the entry memory, and the next request is
// taken only once the final result has been issued; results of a range query
// leave in insertion order, each held until taken, and the scan pauses while
// an earlier result waits at the output.
// Depends on dpst_pkg, dpst_ctrl and dpst_datapath.
module dirty_page_set_table #(
	parameter int CAPACITY  = 64,
	parameter int PAGE_BITS = 52
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dpst_pkg::KIND_W-1:0]  kind,
	input  logic [dpst_pkg::FIELD_W-1:0] page_in,
	input  logic [dpst_pkg::STAMP_W-1:0] stamp_in,
	input  logic [dpst_pkg::FIELD_W-1:0] range_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         status,
	output logic                         found,
	output logic [dpst_pkg::FIELD_W-1:0] page_out,
	output logic [dpst_pkg::STAMP_W-1:0] stamp_out,
	output logic                         last
);
	import dpst_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	dpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	dpst_datapath #(
		.CAPACITY  (CAPACITY),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.page_in     (page_in),
		.stamp_in    (stamp_in),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found       (found),
		.page_out    (page_out),
		.stamp_out   (stamp_out),
		.last        (last)
	);

endmodule

// ===== sv/dpst_checker.sv =====
// Port-level checks for the dirty page set table, bound to the top level.
// Depends on dpst_pkg and dirty_page_set_table.
module dpst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [dpst_pkg::KIND_W-1:0]  kind,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         status,
	input logic                         found,
	input logic [dpst_pkg::FIELD_W-1:0] page_out,
	input logic [dpst_pkg::STAMP_W-1:0] stamp_out,
	input logic                         last
);
	import dpst_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(page_out) && $stable(stamp_out)
		&& $stable(last) && $stable(found) && $stable(status))
		else $error("Result changed before its transfer.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_UNUSED |=> !in_ready)
		else $error("Input taken again before the request finished.");

	a_full_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && !found)
		else $error("Full status on a result that is not a final miss.");

	a_mid_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> found && !status)
		else $error("A result before the last one is not a range hit.");

endmodule

bind dirty_page_set_table dpst_checker u_dpst_checker (.*);
